[rtl/core/bpra_pkg.sv]
// shared constants for the bitmap page run allocator
`default_nettype none

package bpra_pkg;

  // page window geometry
  localparam int unsigned PAGES      = 4096;
  localparam int unsigned PAGE_SHIFT = 12;
  localparam int unsigned PAGE_BYTES = 1 << PAGE_SHIFT;
  localparam int unsigned PAGE_AW    = $clog2(PAGES);

  // used-bit map organisation: one bit per page, 64 pages per word
  localparam int unsigned MAP_W     = 64;
  localparam int unsigned MAP_WORDS = (PAGES + MAP_W - 1) / MAP_W;
  localparam int unsigned WORD_AW   = $clog2(MAP_WORDS);
  localparam int unsigned BIT_AW    = $clog2(MAP_W);
  localparam int unsigned TZ_W      = BIT_AW + 1;

  // payload widths
  localparam int unsigned COUNT_W = 13;
  localparam int unsigned ADDR_W  = 64;
  localparam int unsigned BASE_W  = 32;
  localparam int unsigned SUM_W   = COUNT_W + 1;

  // window bounds
  localparam logic [ADDR_W-1:0] WIN_START = 64'h0000_0000_8000_0000;
  localparam logic [ADDR_W-1:0] WIN_END   =
    WIN_START + ADDR_W'(PAGES) * ADDR_W'(PAGE_BYTES);

  // request modes
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

endpackage

`default_nettype wire

[rtl/core/bpra_ram.sv]
// generic simple dual-port ram with registered read
`default_nettype none

module bpra_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/core/bitmap_page_run_allocator_unit.sv]
// First-fit page run allocator over a used-bit map of the page window.
// Input channel (in_valid / in_ready) carries mode, num_pages and address;
// the result channel (out_valid / out_ready) carries ok and base_address,
// exactly one result per input transaction, in order.
// One request is handled at a time; in_ready is high only while idle.
// The map sits in a 64 x 64-bit ram; one word passes the shared word unit
// per cycle, so the ram read port sets the pace.
// Allocate: scan of up to 64 words (one per cycle, first-fit run search
// across word boundaries), then a restart of the read at the first word of
// the run and a read-modify-write of every word the run covers.
// Free: a check of every covered word, then a clear of every covered word;
// a failed check or a rejected request goes straight to the done state.
// Reset empties the map at once through per-word valid flags (an unwritten
// word reads as all free); no clearing pass is needed.
// The result waits in an output register; a stalled receiver holds the
// block in its done state, after the map update has completed.
`default_nettype none

module bitmap_page_run_allocator_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          mode,
  input  wire logic [bpra_pkg::COUNT_W-1:0]  num_pages,
  input  wire logic [bpra_pkg::ADDR_W-1:0]   address,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               ok,
  output logic      [bpra_pkg::BASE_W-1:0]   base_address
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_PRE  = 3'd2;
  localparam logic [2:0] S_CHK  = 3'd3;
  localparam logic [2:0] S_WR   = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  localparam int unsigned LOG_W = bpra_pkg::BIT_AW;

  logic [2:0]                        state;
  logic                              op_free;
  logic [bpra_pkg::COUNT_W-1:0]      count;
  logic [bpra_pkg::WORD_AW-1:0]      dword;
  logic [bpra_pkg::COUNT_W-1:0]      run;
  logic [bpra_pkg::WORD_AW-1:0]      cur;
  logic [bpra_pkg::PAGE_AW-1:0]      start_page;
  logic [bpra_pkg::PAGE_AW-1:0]      last_page;
  logic                              res_ok;
  logic [bpra_pkg::MAP_WORDS-1:0]    vld;
  logic                              rd_vld;

  logic                              accept;
  logic                              load_res;
  logic [bpra_pkg::WORD_AW-1:0]      rd_addr;
  logic [bpra_pkg::MAP_W-1:0]        rdata;
  logic [bpra_pkg::MAP_W-1:0]        word_q;
  logic                              we;
  logic [bpra_pkg::MAP_W-1:0]        wdata;

  // request checks at acceptance
  logic                              count_bad;
  logic                              in_win;
  logic                              aligned;
  logic [31:0]                       off;
  logic [bpra_pkg::PAGE_AW-1:0]      pg;
  logic [bpra_pkg::SUM_W-1:0]        end_sum;
  logic                              fits;
  logic                              free_bad;

  // word scan unit
  logic [bpra_pkg::MAP_W-1:0]        free_bits;
  logic [bpra_pkg::TZ_W-1:0]         tcnt [0:LOG_W][bpra_pkg::MAP_W];
  logic [bpra_pkg::MAP_W-1:0]        hit;
  logic                              any_hit;
  logic [bpra_pkg::BIT_AW-1:0]       hit_idx;
  logic [bpra_pkg::COUNT_W-1:0]      run_next;
  logic [bpra_pkg::PAGE_AW-1:0]      hit_page;
  logic [bpra_pkg::PAGE_AW-1:0]      hit_first;

  // run mask for the current word
  logic [bpra_pkg::BIT_AW-1:0]       lo;
  logic [bpra_pkg::BIT_AW-1:0]       hi;
  logic [bpra_pkg::MAP_W-1:0]        mask;
  logic                              at_last;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign load_res = (state == S_DONE) && (!out_valid || out_ready);

  // map storage
  bpra_ram #(
    .WIDTH (bpra_pkg::MAP_W),
    .DEPTH (bpra_pkg::MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (we),
    .waddr (cur),
    .wdata (wdata),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  // words never written since reset read as all free
  assign word_q = rd_vld ? rdata : '0;

  // request validation
  always_comb begin
    count_bad = (num_pages == '0) ||
                (num_pages > bpra_pkg::COUNT_W'(bpra_pkg::PAGES));
    in_win    = (address >= bpra_pkg::WIN_START) && (address < bpra_pkg::WIN_END);
    aligned   = (address[bpra_pkg::PAGE_SHIFT-1:0] == '0);
    off       = address[31:0] - bpra_pkg::WIN_START[31:0];
    pg        = off[bpra_pkg::PAGE_SHIFT +: bpra_pkg::PAGE_AW];
    end_sum   = bpra_pkg::SUM_W'(pg) + bpra_pkg::SUM_W'(num_pages);
    fits      = (end_sum <= bpra_pkg::SUM_W'(bpra_pkg::PAGES));
    free_bad  = !(in_win && aligned && fits);
  end

  // trailing free run ending at each bit, built by doubling spans
  assign free_bits = ~word_q;

  always_comb begin
    for (int i = 0; i < bpra_pkg::MAP_W; i++) begin
      tcnt[0][i] = bpra_pkg::TZ_W'(free_bits[i]);
    end
    for (int k = 0; k < LOG_W; k++) begin
      for (int i = 0; i < bpra_pkg::MAP_W; i++) begin
        tcnt[k+1][i] = tcnt[k][i];
      end
      for (int i = (1 << k); i < bpra_pkg::MAP_W; i++) begin
        if (tcnt[k][i] == bpra_pkg::TZ_W'(1 << k)) begin
          tcnt[k+1][i] = bpra_pkg::TZ_W'(1 << k) + tcnt[k][i - (1 << k)];
        end
      end
    end
  end

  // run length at each bit, joined with the run carried in from lower words
  always_comb begin
    for (int i = 0; i < bpra_pkg::MAP_W; i++) begin
      if (tcnt[LOG_W][i] == bpra_pkg::TZ_W'(i + 1)) begin
        hit[i] = (run + bpra_pkg::COUNT_W'(i + 1)) >= count;
      end else begin
        hit[i] = bpra_pkg::COUNT_W'(tcnt[LOG_W][i]) >= count;
      end
    end
  end

  // lowest bit where the run reaches the request
  always_comb begin
    hit_idx = '0;
    for (int i = bpra_pkg::MAP_W - 1; i >= 0; i--) begin
      if (hit[i]) begin
        hit_idx = bpra_pkg::BIT_AW'(i);
      end
    end
  end

  assign any_hit   = |hit;
  assign run_next  = (tcnt[LOG_W][bpra_pkg::MAP_W-1] == bpra_pkg::TZ_W'(bpra_pkg::MAP_W)) ?
                     run + bpra_pkg::COUNT_W'(bpra_pkg::MAP_W) :
                     bpra_pkg::COUNT_W'(tcnt[LOG_W][bpra_pkg::MAP_W-1]);
  assign hit_page  = {dword, hit_idx};
  assign hit_first = bpra_pkg::PAGE_AW'(bpra_pkg::COUNT_W'(hit_page) +
                                        bpra_pkg::COUNT_W'(1) - count);

  // bits of the run inside the current word
  always_comb begin
    lo      = (cur == start_page[bpra_pkg::PAGE_AW-1 -: bpra_pkg::WORD_AW]) ?
              start_page[bpra_pkg::BIT_AW-1:0] : '0;
    hi      = (cur == last_page[bpra_pkg::PAGE_AW-1 -: bpra_pkg::WORD_AW]) ?
              last_page[bpra_pkg::BIT_AW-1:0] : '1;
    mask    = ({bpra_pkg::MAP_W{1'b1}} << lo) &
              ({bpra_pkg::MAP_W{1'b1}} >> (bpra_pkg::BIT_AW'(bpra_pkg::MAP_W - 1) - hi));
    at_last = (cur == last_page[bpra_pkg::PAGE_AW-1 -: bpra_pkg::WORD_AW]);
  end

  // read address and write control
  always_comb begin
    rd_addr = cur + bpra_pkg::WORD_AW'(1);
    we      = 1'b0;
    wdata   = op_free ? (word_q & ~mask) : (word_q | mask);
    unique case (state)
      S_IDLE: begin
        rd_addr = (mode == bpra_pkg::MODE_FREE) ?
                  pg[bpra_pkg::PAGE_AW-1 -: bpra_pkg::WORD_AW] : '0;
      end
      S_SCAN: begin
        rd_addr = dword + bpra_pkg::WORD_AW'(1);
      end
      S_PRE: begin
        rd_addr = cur;
      end
      S_CHK: begin
        if (at_last) begin
          rd_addr = start_page[bpra_pkg::PAGE_AW-1 -: bpra_pkg::WORD_AW];
        end
      end
      S_WR: begin
        we = 1'b1;
      end
      S_DONE: begin
        rd_addr = cur;
      end
      default: begin
        rd_addr = cur;
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      vld       <= '0;
      rd_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_vld <= vld[rd_addr];
      if (we) begin
        vld[cur] <= 1'b1;
      end
      // result handshake
      if (load_res) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op_free <= mode;
            count   <= num_pages;
            dword   <= '0;
            run     <= '0;
            if (count_bad || ((mode == bpra_pkg::MODE_FREE) && free_bad)) begin
              res_ok <= 1'b0;
              state  <= S_DONE;
            end else if (mode == bpra_pkg::MODE_FREE) begin
              start_page <= pg;
              last_page  <= bpra_pkg::PAGE_AW'(pg + num_pages[bpra_pkg::PAGE_AW-1:0] -
                                               bpra_pkg::PAGE_AW'(1));
              cur        <= pg[bpra_pkg::PAGE_AW-1 -: bpra_pkg::WORD_AW];
              state      <= S_CHK;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (any_hit) begin
            start_page <= hit_first;
            last_page  <= hit_page;
            cur        <= hit_first[bpra_pkg::PAGE_AW-1 -: bpra_pkg::WORD_AW];
            state      <= S_PRE;
          end else if (dword == bpra_pkg::WORD_AW'(bpra_pkg::MAP_WORDS - 1)) begin
            res_ok <= 1'b0;
            state  <= S_DONE;
          end else begin
            dword <= dword + bpra_pkg::WORD_AW'(1);
            run   <= run_next;
          end
        end
        S_PRE: begin
          state <= S_WR;
        end
        S_CHK: begin
          if ((word_q & mask) != mask) begin
            res_ok <= 1'b0;
            state  <= S_DONE;
          end else if (at_last) begin
            cur   <= start_page[bpra_pkg::PAGE_AW-1 -: bpra_pkg::WORD_AW];
            state <= S_WR;
          end else begin
            cur <= cur + bpra_pkg::WORD_AW'(1);
          end
        end
        S_WR: begin
          if (at_last) begin
            res_ok <= 1'b1;
            state  <= S_DONE;
          end else begin
            cur <= cur + bpra_pkg::WORD_AW'(1);
          end
        end
        S_DONE: begin
          if (load_res) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (load_res) begin
      ok <= res_ok;
      if (res_ok && (op_free == bpra_pkg::MODE_ALLOC)) begin
        base_address <= bpra_pkg::WIN_START[bpra_pkg::BASE_W-1:0] +
                        (bpra_pkg::BASE_W'(start_page) << bpra_pkg::PAGE_SHIFT);
      end else begin
        base_address <= '0;
      end
    end
  end

endmodule

`default_nettype wire

[verif/tb_bitmap_page_run_allocator_unit.sv]
// self-checking testbench for the bitmap page run allocator unit
`timescale 1ns / 100ps

module tb_bitmap_page_run_allocator_unit;
  import bpra_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 10;
  localparam int RANDOM_ITEMS  = 1200;
  localparam int DRAIN_CYCLES  = 150;
  localparam int CYCLE_LIMIT   = 2000000;
  localparam int IDLE_PERCENT  = 35;
  localparam int HOLD_TRIGGER  = 150;
  localparam int HOLD_CYCLES   = 600;
  localparam int PAUSE_AT      = 600;
  localparam int STEADY_FIRST  = 800;
  localparam int STEADY_LAST   = 1000;
  localparam int REPORT_LIMIT  = 10;

  // how a directed row is checked
  localparam logic EXP_TYPED     = 1'b1;
  localparam logic EXP_PREDICTED = 1'b0;

  typedef struct packed {
    logic              ok;
    logic [BASE_W-1:0] base;
  } result_t;

  typedef struct packed {
    logic               mode;
    logic [COUNT_W-1:0] count;
    logic [ADDR_W-1:0]  addr;
    logic               typed;
    logic               ok;
    logic [BASE_W-1:0]  base;
  } stim_row_t;

  typedef struct packed {
    logic [15:0] first;
    logic [15:0] count;
  } run_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               mode = MODE_ALLOC;
  logic [COUNT_W-1:0] num_pages = '0;
  logic [ADDR_W-1:0]  address = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               ok;
  logic [BASE_W-1:0]  base_address;

  // predictor state and stores
  logic [PAGES-1:0] page_map = '0;
  result_t          pending_results[$];
  stim_row_t        directed_rows[$];
  run_t             live_runs[$];

  int          mismatch_count = 0;
  int          results_seen = 0;
  int unsigned cycle_count = 0;
  logic        steady = 1'b0;
  int          hold_left = 0;
  logic        hold_done = 1'b0;

  bitmap_page_run_allocator_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .num_pages    (num_pages),
    .address      (address),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .ok           (ok),
    .base_address (base_address)
  );

  always #CLK_HALF clk = ~clk;

  // first-fit search; marks the run used and returns its base, 0 when nothing fits
  function automatic logic [BASE_W-1:0] claim_first_run(input int unsigned count);
    int unsigned run_len;
    int unsigned first;
    int unsigned p;
    if (count == 0 || count > PAGES) return '0;
    run_len = 0;
    for (p = 0; p < PAGES; p++) begin
      if (page_map[p]) begin
        run_len = 0;
      end else begin
        run_len++;
        if (run_len == count) begin
          first = p + 1 - count;
          for (int unsigned q = first; q <= p; q++) page_map[q] = 1'b1;
          return WIN_START[BASE_W-1:0] + BASE_W'(first << PAGE_SHIFT);
        end
      end
    end
    return '0;
  endfunction

  // window, alignment and used checks, then clear the whole run
  function automatic logic release_run(input logic [ADDR_W-1:0] addr,
                                       input int unsigned count);
    logic [ADDR_W-1:0] last_addr;
    int unsigned       first;
    if (count == 0 || count > PAGES) return 1'b0;
    if (addr < WIN_START || addr >= WIN_END) return 1'b0;
    if (addr[PAGE_SHIFT-1:0] != '0) return 1'b0;
    last_addr = addr + ADDR_W'(count - 1) * ADDR_W'(PAGE_BYTES);
    if (last_addr >= WIN_END) return 1'b0;
    first = int'((addr - WIN_START) >> PAGE_SHIFT);
    for (int unsigned i = 0; i < count; i++)
      if (!page_map[first + i]) return 1'b0;
    for (int unsigned i = 0; i < count; i++) page_map[first + i] = 1'b0;
    return 1'b1;
  endfunction

  task automatic add_row(input logic m, input logic [COUNT_W-1:0] c,
                         input logic [ADDR_W-1:0] a, input logic typed,
                         input logic exp_ok, input logic [BASE_W-1:0] exp_base);
    stim_row_t row;
    row.mode  = m;
    row.count = c;
    row.addr  = a;
    row.typed = typed;
    row.ok    = exp_ok;
    row.base  = exp_base;
    directed_rows.push_back(row);
  endtask

  // random idle cycles on the request side
  task automatic sender_gap;
    while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // offer one request, wait for the transaction, then record its expectation
  task automatic send_request(input logic m, input logic [COUNT_W-1:0] c,
                              input logic [ADDR_W-1:0] a, input logic typed,
                              input logic exp_ok, input logic [BASE_W-1:0] exp_base,
                              output result_t predicted);
    result_t           want;
    run_t              fresh_run;
    logic [BASE_W-1:0] claimed;
    sender_gap();
    in_valid   <= 1'b1;
    mode       <= m;
    num_pages  <= c;
    address    <= a;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (m == MODE_ALLOC) begin
      claimed = claim_first_run(c);
      predicted.ok   = (claimed != '0);
      predicted.base = claimed;
      if (predicted.ok) begin
        fresh_run.first = 16'((claimed - WIN_START[BASE_W-1:0]) >> PAGE_SHIFT);
        fresh_run.count = 16'(c);
        live_runs.push_back(fresh_run);
      end
    end else begin
      predicted.ok   = release_run(a, c);
      predicted.base = '0;
    end
    want.ok   = exp_ok;
    want.base = exp_base;
    pending_results.push_back(typed == EXP_TYPED ? want : predicted);
  endtask

  // stimulus
  initial begin
    result_t            got;
    run_t               run;
    int                 idx;
    int                 pick;
    int unsigned        k;
    logic               m;
    logic [COUNT_W-1:0] c;
    logic [ADDR_W-1:0]  a;

    // limits and rejects on an empty and on a full map
    add_row(MODE_ALLOC, 13'd1,    '0, EXP_TYPED, 1'b1, 32'h8000_0000);
    add_row(MODE_ALLOC, 13'd0,    '0, EXP_TYPED, 1'b0, 32'h0);
    add_row(MODE_ALLOC, 13'd4097, '0, EXP_TYPED, 1'b0, 32'h0);
    add_row(MODE_ALLOC, 13'd8191, '1, EXP_TYPED, 1'b0, 32'h0);
    add_row(MODE_ALLOC, 13'd4096, '0, EXP_PREDICTED, 1'b0, 32'h0);
    add_row(MODE_FREE,  13'd1,    64'h8000_0000, EXP_TYPED, 1'b1, 32'h0);
    add_row(MODE_ALLOC, 13'd4096, '0, EXP_TYPED, 1'b1, 32'h8000_0000);
    add_row(MODE_ALLOC, 13'd1,    '0, EXP_TYPED, 1'b0, 32'h0);
    add_row(MODE_FREE,  13'd0,    64'h8000_0000, EXP_TYPED, 1'b0, 32'h0);
    add_row(MODE_FREE,  13'd4097, 64'h8000_0000, EXP_TYPED, 1'b0, 32'h0);
    add_row(MODE_FREE,  13'd1,    64'h7FFF_F000, EXP_TYPED, 1'b0, 32'h0);
    add_row(MODE_FREE,  13'd1,    64'h8100_0000, EXP_TYPED, 1'b0, 32'h0);
    add_row(MODE_FREE,  13'd1,    64'hFFFF_FFFF_8000_0000, EXP_TYPED, 1'b0, 32'h0);
    add_row(MODE_FREE,  13'd1,    64'h8000_0800, EXP_TYPED, 1'b0, 32'h0);
    add_row(MODE_FREE,  13'd1,    64'h8000_0001, EXP_TYPED, 1'b0, 32'h0);
    add_row(MODE_FREE,  13'd2,    64'h80FF_F000, EXP_TYPED, 1'b0, 32'h0);
    add_row(MODE_FREE,  13'd1,    64'h80FF_F000, EXP_TYPED, 1'b1, 32'h0);
    // last page now free, so the full-window free must leave the map alone
    add_row(MODE_FREE,  13'd4096, 64'h8000_0000, EXP_TYPED, 1'b0, 32'h0);
    add_row(MODE_FREE,  13'd4095, 64'h8000_0000, EXP_TYPED, 1'b1, 32'h0);
    // holes, first fit and a free across a word boundary
    add_row(MODE_ALLOC, 13'd64,   '0, EXP_TYPED, 1'b1, 32'h8000_0000);
    add_row(MODE_ALLOC, 13'd3,    '0, EXP_PREDICTED, 1'b0, 32'h0);
    add_row(MODE_FREE,  13'd4,    64'h8000_A000, EXP_PREDICTED, 1'b0, 32'h0);
    add_row(MODE_ALLOC, 13'd5,    '0, EXP_PREDICTED, 1'b0, 32'h0);
    add_row(MODE_ALLOC, 13'd4,    '0, EXP_PREDICTED, 1'b0, 32'h0);
    add_row(MODE_FREE,  13'd4,    64'h8003_E000, EXP_PREDICTED, 1'b0, 32'h0);

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      send_request(directed_rows[i].mode, directed_rows[i].count, directed_rows[i].addr,
                   directed_rows[i].typed, directed_rows[i].ok, directed_rows[i].base, got);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady <= (n >= STEADY_FIRST && n < STEADY_LAST);
      // drain everything before carrying on
      if (n == PAUSE_AT) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
      end
      pick = $urandom_range(0, 99);
      if (pick >= 45 && pick < 80 && live_runs.size() != 0) begin
        // free all or the front part of a run handed out earlier
        idx = $urandom_range(0, live_runs.size() - 1);
        run = live_runs[idx];
        k   = ($urandom_range(0, 99) < 70) ? run.count : $urandom_range(1, run.count);
        a   = WIN_START + (ADDR_W'(run.first) << PAGE_SHIFT);
        send_request(MODE_FREE, COUNT_W'(k), a, EXP_PREDICTED, 1'b0, '0, got);
        if (got.ok && k < run.count) begin
          run.first = run.first + 16'(k);
          run.count = run.count - 16'(k);
          live_runs[idx] = run;
        end else begin
          live_runs.delete(idx);
        end
      end else if (pick < 80) begin
        pick = $urandom_range(0, 99);
        if (pick < 80)      c = COUNT_W'($urandom_range(1, 16));
        else if (pick < 95) c = COUNT_W'($urandom_range(17, 256));
        else if (pick < 99) c = COUNT_W'($urandom_range(257, PAGES));
        else                c = COUNT_W'($urandom);
        send_request(MODE_ALLOC, c, ADDR_W'({$urandom, $urandom}), EXP_PREDICTED,
                     1'b0, '0, got);
      end else if (pick < 90) begin
        // aligned free somewhere in the window, used or not
        a = WIN_START + (ADDR_W'($urandom_range(0, PAGES - 1)) << PAGE_SHIFT);
        c = COUNT_W'($urandom_range(1, 8));
        send_request(MODE_FREE, c, a, EXP_PREDICTED, 1'b0, '0, got);
      end else begin
        // noise over every field
        m = $urandom_range(0, 1) ? MODE_FREE : MODE_ALLOC;
        c = COUNT_W'($urandom);
        if ($urandom_range(0, 1)) a = {$urandom, $urandom};
        else                      a = {32'h0, 8'h80, 24'($urandom)};
        send_request(m, c, a, EXP_PREDICTED, 1'b0, '0, got);
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("bitmap_page_run_allocator_unit test passed");
    else
      $display("bitmap_page_run_allocator_unit test failed");
    $finish;
  end

  // result side ready, with one long hold-off to back the block up
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= HOLD_TRIGGER) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end
  end

  // compare each result transaction with the oldest expectation
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen <= results_seen + 1;
      if (pending_results.size() == 0) begin
        if (mismatch_count < REPORT_LIMIT)
          $display("unexpected result %0d: ok %0b base %h", results_seen, ok, base_address);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (ok !== want.ok || base_address !== want.base) begin
          if (mismatch_count < REPORT_LIMIT)
            $display("result %0d mismatch: ok exp %0b got %0b, base exp %h got %h",
                     results_seen, want.ok, ok, want.base, base_address);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("bitmap_page_run_allocator_unit test failed");
      $finish;
    end
  end

endmodule
